// ===== sv/rrtm_pkg.sv =====
package rrtm_pkg;

    localparam int RR_W   = 13;
    localparam int RATE_W = 20;
    localparam int SR_W   = 10;
    localparam int CFG_W  = 13;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_LONG_THR    = 1'b1;

    localparam logic [SR_W-1:0]          SR_RESET   = 10'd250;
    localparam logic [RR_W-1:0]          THR_RESET  = 13'd300;
    localparam logic [RR_W-1:0]          MIN_START  = 13'd5120;
    localparam logic signed [RATE_W-1:0] RATE_NONE  = -20'sd100;
    localparam logic signed [RATE_W-1:0] RATE_LIMIT = 20'sd524287;

    localparam int RR_MAX    = 8191;
    localparam int RATE_MAX  = 524287;
    localparam int MIN_VALID = 5;
    localparam int SLOW_N    = 4;
    localparam int MUL_K     = 600;
    localparam int DIV_K     = 10;
    localparam int ROUND_K   = 4;

    // Multiplying by DIV10_RECIP and dropping DIV10_SHIFT bits divides by ten exactly below 2**26.
    localparam int          DIV10_SHIFT = 27;
    localparam logic [23:0] DIV10_RECIP = 24'd13421773;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_WALK  = 9'b000000100,
        S_TRIM  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIV1  = 9'b000100000,
        S_WAIT1 = 9'b001000000,
        S_DIV2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic shift;
        logic setup;
        logic walk;
        logic trim;
        logic mul;
        logic no_rate;
        logic hold;
        logic div_start;
        logic take_q;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic last;
        logic zero;
        logic div_busy;
    } t_status;

endpackage

// ===== sv/rrtm_div.sv =====
module rrtm_div
    import rrtm_pkg::*;
#(
    parameter int DVD_W = 25,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;
    logic [DVS_W-1:0] n_rem;

    assign w_sh   = {r_rem, r_quo[DVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign n_rem  = w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== sv/rrtm_dp.sv =====
module rrtm_dp
    import rrtm_pkg::*;
#(
    parameter int RR_DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic [RR_W-1:0]          i_rr_interval,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic signed [RATE_W-1:0] o_heart_rate,
    output logic                     o_fresh
);

    localparam int CNT_W  = $clog2(RR_DEPTH + 1);
    localparam int IDX_W  = $clog2(RR_DEPTH);
    localparam int TOT_W  = $clog2(RR_DEPTH * RR_MAX + 1);
    localparam int NUM_W  = $clog2(MUL_K * RR_DEPTH * ((1 << SR_W) - 1) + 1);
    localparam int Q_W    = NUM_W + 1;
    localparam int PROD_W = Q_W + DIV10_SHIFT;

    logic [RR_W-1:0]          r_hist [RR_DEPTH];
    logic [SR_W-1:0]          r_sr;
    logic [RR_W-1:0]          r_thr;
    logic [CNT_W-1:0]         r_n;
    logic [IDX_W-1:0]         r_idx;
    logic [TOT_W-1:0]         r_total;
    logic [RR_W-1:0]          r_hi;
    logic [RR_W-1:0]          r_lo;
    logic [NUM_W-1:0]         r_num;
    logic [Q_W-1:0]           r_q;
    logic signed [RATE_W-1:0] r_held;
    logic                     r_fresh;
    logic signed [RATE_W-1:0] r_out_rate;
    logic                     r_out_fresh;

    logic [CNT_W-1:0]  w_count;
    logic              w_slow;
    logic [RR_W-1:0]   w_v;
    logic [Q_W-1:0]    w_dvd;
    logic [TOT_W-1:0]  w_dvs;
    logic              w_busy;
    logic [Q_W-1:0]    w_quo;
    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    w_rate_q;

    always_comb begin
        w_count = '0;
        for (int i = 0; i < RR_DEPTH; i++) begin
            w_count = w_count + CNT_W'(r_hist[i] != '0);
        end
    end

    assign w_slow = (r_hist[0] >= r_thr) && (r_hist[1] >= r_thr) && (r_hist[2] >= r_thr);
    assign w_v    = r_hist[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= SR_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_RATE: r_sr  <= i_cfg_wdata[SR_W-1:0];
                CFG_LONG_THR:    r_thr <= i_cfg_wdata[RR_W-1:0];
                default:         r_sr  <= r_sr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RR_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_hist[0] <= i_rr_interval;
            for (int i = 1; i < RR_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_n     <= w_slow ? CNT_W'(SLOW_N) : w_count;
            r_idx   <= '0;
            r_total <= '0;
            r_hi    <= '0;
            r_lo    <= MIN_START;
        end else if (i_cmd.walk) begin
            r_idx   <= r_idx + IDX_W'(1);
            r_total <= r_total + TOT_W'(w_v);
            if (w_v > r_hi) begin
                r_hi <= w_v;
            end
            if (w_v < r_lo) begin
                r_lo <= w_v;
            end
        end else if (i_cmd.trim) begin
            if (r_n > CNT_W'(SLOW_N)) begin
                r_total <= r_total - TOT_W'(r_lo) - TOT_W'(r_hi);
                r_n     <= r_n - CNT_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= NUM_W'(MUL_K * r_n * r_sr);
        end
        if (i_cmd.take_q) begin
            r_q <= w_quo + Q_W'(ROUND_K);
        end
    end

    assign w_dvd = Q_W'(r_num);
    assign w_dvs = r_total;

    rrtm_div #(
        .DVD_W (Q_W),
        .DVS_W (TOT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    assign w_prod   = PROD_W'(r_q) * PROD_W'(DIV10_RECIP);
    assign w_rate_q = w_prod[PROD_W-1:DIV10_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= RATE_NONE;
            r_fresh <= 1'b0;
        end else if (i_cmd.no_rate) begin
            r_held  <= RATE_NONE;
            r_fresh <= 1'b1;
        end else if (i_cmd.finish) begin
            r_held  <= (w_rate_q > Q_W'(RATE_MAX)) ? RATE_LIMIT : RATE_W'(w_rate_q);
            r_fresh <= 1'b1;
        end else if (i_cmd.hold) begin
            r_fresh <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rate  <= r_held;
            r_out_fresh <= r_fresh;
        end
    end

    assign o_status.few      = (w_count < CNT_W'(MIN_VALID));
    assign o_status.last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_n);
    assign o_status.zero     = (r_total == '0);
    assign o_status.div_busy = w_busy;

    assign o_heart_rate = r_out_rate;
    assign o_fresh      = r_out_fresh;

endmodule

// ===== sv/rrtm_ctrl.sv =====
module rrtm_ctrl
    import rrtm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    input  t_status i_status,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.few) begin
                    o_cmd.hold = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.last) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (i_status.zero) begin
                    o_cmd.no_rate = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT1;
            end
            S_WAIT1: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = S_DIV2;
                end
            end
            S_DIV2: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

// ===== sv/rr_trimmed_mean_heart_rate.sv =====
// With fewer than five intervals valid the held rate goes out without a walk; otherwise the
// history is walked, n being the number of intervals walked, and a zero total skips the divider.
// The walk takes one history entry per cycle and the bit-serial divider yields one quotient
// bit per cycle; the final division by ten is a reciprocal multiply.
// The input is ready again once the result is loaded; loading waits for a free output register.
// A synchronous active-low reset clears the history, sets the held rate to -100, loads the
// default sample rate and threshold, and empties the output register.
module rr_trimmed_mean_heart_rate
    import rrtm_pkg::*;
#(
    parameter int RR_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,   // rr_interval[12:0], zero padding
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // heart_rate[19:0], zero padding
    output logic             o_m_axis_tuser    // fresh
);

    t_cmd                     w_cmd;
    t_status                  w_status;
    logic signed [RATE_W-1:0] w_rate;
    logic                     w_fresh;

    rrtm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (w_status),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    rrtm_dp #(
        .RR_DEPTH (RR_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_rr_interval (i_s_axis_tdata[RR_W-1:0]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_heart_rate  (w_rate),
        .o_fresh       (w_fresh)
    );

    assign o_m_axis_tdata = {4'b0000, w_rate};
    assign o_m_axis_tuser = w_fresh;

endmodule

// ===== dv/rr_trimmed_mean_heart_rate_checker.sv =====
module rr_trimmed_mean_heart_rate_checker
    import rrtm_pkg::*;
#(
    parameter int RR_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,   // rr_interval[12:0], zero padding
    input  logic             i_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  logic [23:0]      i_m_axis_tdata,   // heart_rate[19:0], zero padding
    input  logic             i_m_axis_tuser,   // fresh
    output int               o_mismatches,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RATE_W-1:0] bpm;
        logic                     fresh;
    } t_rate_word;

    logic [RR_W-1:0]          rr_hist [RR_DEPTH];
    logic signed [RATE_W-1:0] held_bpm;
    logic [SR_W-1:0]          cfg_rate;
    logic [RR_W-1:0]          cfg_thr;
    t_rate_word               rate_queue [$];
    int                       mismatches = 0;
    int                       pending_words = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending_words;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 200) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Shifts one interval into the history and queues the rate word it should produce.
    task automatic take_interval(input logic [RR_W-1:0] rr);
        int unsigned valid_cnt;
        int unsigned n;
        int unsigned total;
        int unsigned lo;
        int unsigned hi;
        int unsigned q;
        logic        slow;
        t_rate_word  w;
        for (int i = RR_DEPTH - 1; i > 0; i--) begin
            rr_hist[i] = rr_hist[i-1];
        end
        rr_hist[0] = rr;
        valid_cnt = 0;
        foreach (rr_hist[i]) begin
            if (rr_hist[i] != '0) valid_cnt++;
        end
        if (valid_cnt < MIN_VALID) begin
            w.bpm   = held_bpm;
            w.fresh = 1'b0;
        end else begin
            slow = (rr_hist[0] >= cfg_thr) && (rr_hist[1] >= cfg_thr) &&
                   (rr_hist[2] >= cfg_thr);
            n     = slow ? SLOW_N : valid_cnt;
            total = 0;
            hi    = 0;
            lo    = MIN_START;
            for (int i = 0; i < n; i++) begin
                if (rr_hist[i] > hi) hi = rr_hist[i];
                if (rr_hist[i] < lo) lo = rr_hist[i];
                total += rr_hist[i];
            end
            if (n > SLOW_N) begin
                total -= lo + hi;
                n -= 2;
            end
            if (total != 0) begin
                q = (MUL_K * n * cfg_rate) / total;
                q = (q + ROUND_K) / DIV_K;
                held_bpm = (q > RATE_MAX) ? RATE_LIMIT : RATE_W'(q);
            end else begin
                held_bpm = RATE_NONE;
            end
            w.bpm   = held_bpm;
            w.fresh = 1'b1;
        end
        rate_queue.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_rate_word w;
        if (!i_rst_n) begin
            foreach (rr_hist[i]) rr_hist[i] = '0;
            held_bpm = RATE_NONE;
            cfg_rate = SR_RESET;
            cfg_thr  = THR_RESET;
            rate_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_RATE: cfg_rate = i_cfg_wdata[SR_W-1:0];
                    CFG_LONG_THR:    cfg_thr  = i_cfg_wdata[RR_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                take_interval(i_s_axis_tdata[RR_W-1:0]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (rate_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, rate %0d fresh %0b",
                        $signed(i_m_axis_tdata[RATE_W-1:0]), i_m_axis_tuser));
                end else begin
                    w = rate_queue.pop_front();
                    if (i_m_axis_tdata[RATE_W-1:0] !== w.bpm) begin
                        report_mismatch($sformatf("heart_rate %0d, wanted %0d",
                            $signed(i_m_axis_tdata[RATE_W-1:0]), w.bpm));
                    end
                    if (i_m_axis_tdata[23:RATE_W] !== '0) begin
                        report_mismatch($sformatf("padding bits %b not zero",
                            i_m_axis_tdata[23:RATE_W]));
                    end
                    if (i_m_axis_tuser !== w.fresh) begin
                        report_mismatch($sformatf("fresh %b, wanted %b",
                            i_m_axis_tuser, w.fresh));
                    end
                end
            end
        end
        pending_words = rate_queue.size();
    end

endmodule

// ===== dv/tb_rr_trimmed_mean_heart_rate.sv =====
module tb_rr_trimmed_mean_heart_rate;
    import rrtm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RR_DEPTH  = 8;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 150;

    typedef enum int {
        RK_STEADY,
        RK_SLOW,
        RK_DROPOUT,
        RK_NOISE,
        RK_LONG,
        RK_EDGE
    } t_run_kind;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    logic             cfg_idx     = CFG_SAMPLE_RATE;
    logic [CFG_W-1:0] cfg_wdata   = '0;
    logic             rr_tvalid   = 1'b0;
    logic             rr_tready;
    logic [15:0]      rr_tdata    = '0;
    logic             rate_tvalid;
    logic             rate_tready = 1'b0;
    logic [23:0]      rate_tdata;
    logic             rate_tuser;
    int               mismatches;
    int               pending_words;
    logic             send_calm   = 1'b1;
    logic             recv_calm   = 1'b1;
    int               cur_rate    = SR_RESET;
    int               cur_thr     = THR_RESET;

    always #5ns clk = ~clk;

    rr_trimmed_mean_heart_rate #(
        .RR_DEPTH(RR_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(rr_tvalid),
        .o_s_axis_tready(rr_tready),
        .i_s_axis_tdata (rr_tdata),
        .o_m_axis_tvalid(rate_tvalid),
        .i_m_axis_tready(rate_tready),
        .o_m_axis_tdata (rate_tdata),
        .o_m_axis_tuser (rate_tuser)
    );

    rr_trimmed_mean_heart_rate_checker #(
        .RR_DEPTH(RR_DEPTH)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(rr_tvalid),
        .i_s_axis_tready(rr_tready),
        .i_s_axis_tdata (rr_tdata),
        .i_m_axis_tvalid(rate_tvalid),
        .i_m_axis_tready(rate_tready),
        .i_m_axis_tdata (rate_tdata),
        .i_m_axis_tuser (rate_tuser),
        .o_mismatches   (mismatches),
        .o_pending      (pending_words)
    );

    function automatic logic [RR_W-1:0] to_rr(input int v);
        if (v < 0) return '0;
        if (v > RR_MAX) return RR_W'(RR_MAX);
        return RR_W'(v);
    endfunction

    task automatic send_rr(input logic [RR_W-1:0] rr);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0) begin
            rr_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rr_tvalid = 1'b1;
        rr_tdata  = 16'(rr);
        do @(posedge clk); while (!rr_tready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        rr_tvalid = 1'b0;
        while (pending_words != 0) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Outside calm stretches the rate side holds ready low for a random gap before taking each word;
    // in calm stretches it takes every word at once.
    initial begin
        int gap;
        int words;
        words = 0;
        forever begin
            @(negedge clk);
            if (words % 24 == 0) recv_calm = ($urandom_range(0, 2) == 0);
            gap = recv_calm ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                rate_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rate_tready = 1'b1;
            do @(posedge clk); while (!rate_tvalid);
            words++;
        end
    end

    initial begin
        int               directed_rr [] = '{
            0, 8191, 1, 250, 240, 260, 0, 255, 300, 310, 8191, 299,
            6000, 7000, 5500, 8000, 6100, 0, 0, 0, 0, 1, 1, 1, 1, 1
        };
        int               pick;
        int               run_left;
        int               bpm;
        int               beat;
        t_run_kind        run_kind;
        logic [RR_W-1:0]  rr;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Default settings: short start-up history, slow rhythm, long and zero intervals.
        send_calm = 1'b1;
        foreach (directed_rr[i]) begin
            send_rr(to_rr(directed_rr[i]));
        end

        run_left = 0;
        run_kind = RK_STEADY;
        beat     = 250;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin cur_rate = 1;        cur_thr = 1;         end
                1: begin cur_rate = 1000;     cur_thr = 8191;      end
                2: begin cur_rate = 0;        cur_thr = 0;         end
                3: begin cur_rate = 1023;     cur_thr = 1;         end
                4: begin cur_rate = SR_RESET; cur_thr = THR_RESET; end
                5: begin
                    cur_rate = $urandom_range(1, 1000);
                    cur_thr  = $urandom_range(1, 8191);
                end
                default: begin
                    cur_rate = $urandom_range(100, 1000);
                    cur_thr  = to_rr(cur_rate * 6 / 5 + $urandom_range(0, 40) - 20);
                end
            endcase
            write_cfg(CFG_SAMPLE_RATE, cur_rate);
            write_cfg(CFG_LONG_THR, cur_thr);

            for (int k = 0; k < PHASE_LEN; k++) begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)      run_kind = RK_STEADY;
                    else if (pick < 65) run_kind = RK_SLOW;
                    else if (pick < 73) run_kind = RK_DROPOUT;
                    else if (pick < 85) run_kind = RK_NOISE;
                    else if (pick < 93) run_kind = RK_LONG;
                    else                run_kind = RK_EDGE;
                    run_left  = $urandom_range(1, 12);
                    send_calm = ($urandom_range(0, 3) == 0);
                    bpm       = $urandom_range(30, 240);
                    beat      = (cur_rate == 0) ? $urandom_range(1, 400)
                                                : cur_rate * 60 / bpm;
                    if (beat < 1) beat = 1;
                end
                case (run_kind)
                    RK_STEADY:  rr = to_rr(beat + $urandom_range(0, beat / 4) - beat / 8);
                    RK_SLOW:    rr = to_rr(cur_thr + $urandom_range(0, 400));
                    RK_DROPOUT: rr = '0;
                    RK_NOISE:   rr = RR_W'($urandom_range(0, RR_MAX));
                    RK_LONG:    rr = RR_W'($urandom_range(MIN_START + 1, RR_MAX));
                    default: begin
                        case ($urandom_range(0, 5))
                            0:       rr = '0;
                            1:       rr = RR_W'(1);
                            2:       rr = RR_W'(RR_MAX);
                            3:       rr = RR_W'(RR_MAX - 1);
                            4:       rr = to_rr(cur_thr);
                            default: rr = to_rr(cur_thr - 1);
                        endcase
                    end
                endcase
                run_left--;
                send_rr(rr);
            end
        end

        drain_results();
        repeat (80) @(negedge clk);
        if (mismatches == 0 && pending_words == 0) begin
            $display("rr_trimmed_mean_heart_rate verification clean");
        end else begin
            $display("rr_trimmed_mean_heart_rate verification failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("rr_trimmed_mean_heart_rate verification failed");
        $finish;
    end

endmodule

// ===== rr_trimmed_mean_heart_rate.f =====
sv/rrtm_pkg.sv
sv/rrtm_div.sv
sv/rrtm_dp.sv
sv/rrtm_ctrl.sv
sv/rr_trimmed_mean_heart_rate.sv
dv/rr_trimmed_mean_heart_rate_checker.sv
dv/tb_rr_trimmed_mean_heart_rate.sv
